// ----- rtl/pf66_pkg.sv -----
// ----------------------------------------------------------------------------
// pf66_pkg
// Shared types, constants and character helpers for the 6x6 Playfair encoder.
// ----------------------------------------------------------------------------
package pf66_pkg;

  // square geometry
  localparam int SQ_SIDE    = 6;
  localparam int CELL_COUNT = SQ_SIDE * SQ_SIDE;
  localparam int SYM_W      = $clog2(CELL_COUNT);
  localparam int RC_W       = $clog2(SQ_SIDE);
  localparam int POS_W      = 2 * RC_W;
  localparam int CHAR_W     = 8;
  localparam int ACT_W      = 2;

  // symbol alphabet: letters first, then digits
  localparam int LETTER_COUNT = 26;

  localparam logic [CHAR_W-1:0] ASCII_UA = 8'h41;
  localparam logic [CHAR_W-1:0] ASCII_UZ = 8'h5A;
  localparam logic [CHAR_W-1:0] ASCII_LA = 8'h61;
  localparam logic [CHAR_W-1:0] ASCII_LZ = 8'h7A;
  localparam logic [CHAR_W-1:0] ASCII_D0 = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_D9 = 8'h39;
  localparam logic [CHAR_W-1:0] ASCII_X  = 8'h58;

  // pad symbol index for an odd leftover
  localparam logic [SYM_W-1:0] PAD_SYM = SYM_W'(ASCII_X - ASCII_UA);
  localparam logic [SYM_W-1:0] LAST_SYM = SYM_W'(CELL_COUNT - 1);

  // input actions
  typedef enum logic [ACT_W-1:0] {
    ACT_KEY_CHAR = 2'd0,
    ACT_KEY_END  = 2'd1,
    ACT_MSG_CHAR = 2'd2,
    ACT_MSG_END  = 2'd3
  } action_t;

  // filtered character
  typedef struct packed {
    logic             ok;
    logic [SYM_W-1:0] idx;
  } sym_t;

  // controller to datapath
  typedef struct packed {
    logic place_key;
    logic sweep_clr;
    logic place_sweep;
    logic set_kc;
    logic hold_load;
    logic hold_clr;
    logic q_load;
    logic q_pad;
    logic pos_rd_p;
    logic pos_rd_q;
    logic cell_rd1;
    logic cell_rd2;
    logic out_load1;
    logic out_load2;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic key_complete;
    logic sym_ok;
    logic held_valid;
    logic sweep_last;
    logic out_free;
  } dp_sts_t;

  // keep letters and digits, fold lower case, map to symbol index
  function automatic sym_t filter_char(logic [CHAR_W-1:0] c);
    sym_t              s;
    logic [CHAR_W-1:0] d;
    s.ok  = 1'b0;
    s.idx = '0;
    d     = '0;
    if (c >= ASCII_LA && c <= ASCII_LZ) begin
      d     = c - ASCII_LA;
      s.ok  = 1'b1;
      s.idx = d[SYM_W-1:0];
    end else if (c >= ASCII_UA && c <= ASCII_UZ) begin
      d     = c - ASCII_UA;
      s.ok  = 1'b1;
      s.idx = d[SYM_W-1:0];
    end else if (c >= ASCII_D0 && c <= ASCII_D9) begin
      d     = c - ASCII_D0 + CHAR_W'(LETTER_COUNT);
      s.ok  = 1'b1;
      s.idx = d[SYM_W-1:0];
    end
    return s;
  endfunction

  // symbol index back to ascii
  function automatic logic [CHAR_W-1:0] char_of_sym(logic [SYM_W-1:0] idx);
    logic [CHAR_W-1:0] wide;
    wide = CHAR_W'(idx);
    if (wide < CHAR_W'(LETTER_COUNT)) begin
      return ASCII_UA + wide;
    end
    return ASCII_D0 + wide - CHAR_W'(LETTER_COUNT);
  endfunction

  // cell address from row and column
  function automatic logic [SYM_W-1:0] cell_addr(logic [RC_W-1:0] row,
                                                  logic [RC_W-1:0] col);
    return SYM_W'(row) * SYM_W'(SQ_SIDE) + SYM_W'(col);
  endfunction

endpackage

// ----- rtl/pf66_in_if.sv -----
// ----------------------------------------------------------------------------
// pf66_in_if
// Input channel: action code and character, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pf66_in_if;
  logic                          valid;
  logic                          ready;
  logic [pf66_pkg::ACT_W-1:0]    action;
  logic [pf66_pkg::CHAR_W-1:0]   char_in;

  modport source (output valid, action, char_in, input ready);
  modport sink   (input valid, action, char_in, output ready);
endinterface

// ----- rtl/pf66_out_if.sv -----
// ----------------------------------------------------------------------------
// pf66_out_if
// Result channel: cipher character and pair marker, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pf66_out_if;
  logic                          valid;
  logic                          ready;
  logic [pf66_pkg::CHAR_W-1:0]   cipher_char;
  logic                          last_of_pair;

  modport source (output valid, cipher_char, last_of_pair, input ready);
  modport sink   (input valid, cipher_char, last_of_pair, output ready);
endinterface

// ----- rtl/pf66_ram.sv -----
// ----------------------------------------------------------------------------
// pf66_ram
// Generic single-write, single-read RAM with registered, enabled read.
// ----------------------------------------------------------------------------
module pf66_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 36
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // read port, data held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/pf66_datapath.sv -----
// ----------------------------------------------------------------------------
// pf66_datapath
// Key square storage, symbol placement, pair lookup and result register.
// ----------------------------------------------------------------------------
module pf66_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [pf66_pkg::CHAR_W-1:0] char_in,
  input  pf66_pkg::dp_cmd_t           cmd,
  output pf66_pkg::dp_sts_t           sts,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [pf66_pkg::CHAR_W-1:0] out_char,
  output logic                        out_last
);

  localparam int SYM_W = pf66_pkg::SYM_W;
  localparam int RC_W  = pf66_pkg::RC_W;
  localparam int POS_W = pf66_pkg::POS_W;

  // state
  logic [SYM_W-1:0]               fill_count_r;
  logic [RC_W-1:0]                fill_row_r;
  logic [RC_W-1:0]                fill_col_r;
  logic [pf66_pkg::CELL_COUNT-1:0] present_r;
  logic                           key_complete_r;
  logic [SYM_W-1:0]               held_sym_r;
  logic                           held_valid_r;
  logic [SYM_W-1:0]               q_sym_r;
  logic [SYM_W-1:0]               sweep_r;
  logic [POS_W-1:0]               p_pos_r;
  logic [POS_W-1:0]               q_pos_r;
  logic                           out_valid_r;
  logic [pf66_pkg::CHAR_W-1:0]    out_char_r;
  logic                           out_last_r;

  // memory ports
  pf66_pkg::sym_t   in_sym;
  logic [SYM_W-1:0] place_sym;
  logic             do_place;
  logic [POS_W-1:0] pos_rdata;
  logic [SYM_W-1:0] pos_raddr;
  logic [SYM_W-1:0] cell_rdata;
  logic [SYM_W-1:0] cell_raddr;
  logic             fill_open;

  assign in_sym = pf66_pkg::filter_char(char_in);

  // placement of a key symbol or a sweep symbol into the next free cell
  assign place_sym = cmd.place_sweep ? sweep_r : in_sym.idx;
  assign fill_open = (fill_count_r != pf66_pkg::LAST_SYM) ||
                     !(fill_row_r == RC_W'(pf66_pkg::SQ_SIDE - 1) &&
                       fill_col_r == RC_W'(pf66_pkg::SQ_SIDE)) ;
  assign do_place  = (cmd.place_key || cmd.place_sweep) && !present_r[place_sym] &&
                     (32'(fill_count_r) < pf66_pkg::CELL_COUNT) && fill_open;

  // lookup addresses
  assign pos_raddr  = cmd.pos_rd_p ? held_sym_r : q_sym_r;
  assign cell_raddr = cmd.cell_rd1 ?
                      pf66_pkg::cell_addr(p_pos_r[POS_W-1:RC_W], pos_rdata[RC_W-1:0]) :
                      pf66_pkg::cell_addr(q_pos_r[POS_W-1:RC_W], p_pos_r[RC_W-1:0]);

  // symbol to {row, col}
  pf66_ram #(
    .WIDTH (POS_W),
    .DEPTH (pf66_pkg::CELL_COUNT)
  ) u_pos_ram (
    .clk   (clk),
    .we    (do_place),
    .waddr (place_sym),
    .wdata ({fill_row_r, fill_col_r}),
    .re    (cmd.pos_rd_p || cmd.pos_rd_q),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  // cell to symbol
  pf66_ram #(
    .WIDTH (SYM_W),
    .DEPTH (pf66_pkg::CELL_COUNT)
  ) u_cell_ram (
    .clk   (clk),
    .we    (do_place),
    .waddr (fill_count_r),
    .wdata (place_sym),
    .re    (cmd.cell_rd1 || cmd.cell_rd2),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  // key fill state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_count_r   <= '0;
      fill_row_r     <= '0;
      fill_col_r     <= '0;
      present_r      <= '0;
      key_complete_r <= 1'b0;
      sweep_r        <= '0;
    end else begin
      if (do_place) begin
        fill_count_r         <= fill_count_r + 1'b1;
        present_r[place_sym] <= 1'b1;
        if (fill_col_r == RC_W'(pf66_pkg::SQ_SIDE - 1)) begin
          fill_col_r <= '0;
          fill_row_r <= fill_row_r + 1'b1;
        end else begin
          fill_col_r <= fill_col_r + 1'b1;
        end
      end
      if (cmd.sweep_clr) begin
        sweep_r <= '0;
      end else if (cmd.place_sweep) begin
        sweep_r <= sweep_r + 1'b1;
      end
      if (cmd.set_kc) begin
        key_complete_r <= 1'b1;
      end
    end
  end

  // held character and pending pair
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
      held_sym_r   <= '0;
    end else begin
      if (cmd.hold_load) begin
        held_sym_r   <= in_sym.idx;
        held_valid_r <= 1'b1;
      end else if (cmd.hold_clr) begin
        held_valid_r <= 1'b0;
      end
    end
  end

  // second symbol of the pair and looked-up positions
  always_ff @(posedge clk) begin
    if (cmd.q_load) begin
      q_sym_r <= in_sym.idx;
    end else if (cmd.q_pad) begin
      q_sym_r <= pf66_pkg::PAD_SYM;
    end
    if (cmd.pos_rd_q) begin
      p_pos_r <= pos_rdata;
    end
    if (cmd.cell_rd1) begin
      q_pos_r <= pos_rdata;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load1 || cmd.out_load2) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load1 || cmd.out_load2) begin
      out_char_r <= pf66_pkg::char_of_sym(cell_rdata);
      out_last_r <= cmd.out_load2;
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

  // status
  assign sts.key_complete = key_complete_r;
  assign sts.sym_ok       = in_sym.ok;
  assign sts.held_valid   = held_valid_r;
  assign sts.sweep_last   = (sweep_r == pf66_pkg::LAST_SYM);
  assign sts.out_free     = !out_valid_r || out_ready;

endmodule

// ----- rtl/pf66_ctrl.sv -----
// ----------------------------------------------------------------------------
// pf66_ctrl
// Sequencer: accepts actions, runs the end-of-key sweep and the pair lookup.
// ----------------------------------------------------------------------------
module pf66_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [pf66_pkg::ACT_W-1:0] in_action,
  output logic                       in_ready,
  input  pf66_pkg::dp_sts_t          sts,
  output pf66_pkg::dp_cmd_t          cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_POS_P,
    ST_POS_Q,
    ST_CELL,
    ST_OUT1,
    ST_OUT2
  } state_t;

  state_t            state_r;
  state_t            state_nxt;
  pf66_pkg::action_t act;
  logic              acc;

  assign act      = pf66_pkg::action_t'(in_action);
  assign in_ready = (state_r == ST_IDLE);
  assign acc      = in_valid && in_ready;

  // commands and next state
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          unique case (act)
            pf66_pkg::ACT_KEY_CHAR: begin
              cmd.place_key = !sts.key_complete && sts.sym_ok;
            end
            pf66_pkg::ACT_KEY_END: begin
              if (!sts.key_complete) begin
                cmd.sweep_clr = 1'b1;
                state_nxt     = ST_FILL;
              end
            end
            pf66_pkg::ACT_MSG_CHAR: begin
              if (sts.key_complete && sts.sym_ok) begin
                if (!sts.held_valid) begin
                  cmd.hold_load = 1'b1;
                end else begin
                  cmd.hold_clr = 1'b1;
                  cmd.q_load   = 1'b1;
                  state_nxt    = ST_POS_P;
                end
              end
            end
            pf66_pkg::ACT_MSG_END: begin
              cmd.hold_clr = 1'b1;
              if (sts.key_complete && sts.held_valid) begin
                cmd.q_pad = 1'b1;
                state_nxt = ST_POS_P;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FILL: begin
        cmd.place_sweep = 1'b1;
        if (sts.sweep_last) begin
          cmd.set_kc = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_POS_P: begin
        cmd.pos_rd_p = 1'b1;
        state_nxt    = ST_POS_Q;
      end
      ST_POS_Q: begin
        cmd.pos_rd_q = 1'b1;
        state_nxt    = ST_CELL;
      end
      ST_CELL: begin
        cmd.cell_rd1 = 1'b1;
        state_nxt    = ST_OUT1;
      end
      ST_OUT1: begin
        if (sts.out_free) begin
          cmd.out_load1 = 1'b1;
          cmd.cell_rd2  = 1'b1;
          state_nxt     = ST_OUT2;
        end
      end
      ST_OUT2: begin
        if (sts.out_free) begin
          cmd.out_load2 = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/playfair_6x6_encoder_top.sv -----
// ----------------------------------------------------------------------------
// playfair_6x6_encoder_top
// Playfair-style encoder on a 6x6 key square of letters and digits.
//
//   channel  | dir | handshake        | payload
//   ---------+-----+------------------+---------------------------------
//   in_ch    | in  | valid / ready    | action[1:0], char_in[7:0]
//   out_ch   | out | valid / ready    | cipher_char[7:0], last_of_pair
//
// Key characters, and message characters that do not complete a pair, are
// taken in the idle state. The first end of key starts a sweep over all
// symbols, one symbol per cycle; a repeated one starts no sweep. A completed
// pair, or an end of message that pads a leftover, reads both positions and
// then both cells, set by the single read port of the position and square
// memories, and waits while the result channel stalls. Reset is synchronous
// and needs no clearing pass; memories are read only once the key is complete.
// ----------------------------------------------------------------------------
module playfair_6x6_encoder_top (
  input  logic              clk,
  input  logic              rst_n,
  pf66_in_if.sink           in_ch,
  pf66_out_if.source        out_ch
);

  pf66_pkg::dp_cmd_t cmd;
  pf66_pkg::dp_sts_t sts;

  // sequencer
  pf66_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // square storage and lookup
  pf66_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .char_in   (in_ch.char_in),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_char  (out_ch.cipher_char),
    .out_last  (out_ch.last_of_pair)
  );

  // key stays complete until reset
  a_kc_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    sts.key_complete |=> sts.key_complete)
    else $error("key complete flag dropped");

  // result register only loaded when free
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load1 || cmd.out_load2) |-> sts.out_free)
    else $error("result overwritten before transaction");

  // sweep only runs before key completion
  a_sweep_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.place_sweep |-> !sts.key_complete)
    else $error("sweep after key complete");

  // second result follows a first one
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load2 |-> $past(cmd.out_load1) || out_ch.valid)
    else $error("second result without first");

endmodule
